FILE: rtl/core/prime_factor_sieve_table_defines.svh
// Assertion macros for the prime factor sieve table block.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef PRIME_FACTOR_SIEVE_TABLE_DEFINES_SVH
`define PRIME_FACTOR_SIEVE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PFST_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define PFST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/pfst_pkg.sv
// Package for the prime factor sieve table block: widths, codes, FSM states.
// No dependencies.
`default_nettype none

package pfst_pkg;

	localparam int ValW       = 18;
	localparam int CntW       = 5;
	localparam int MaxResults = 18;
	localparam logic [ValW-1:0] MaxValue = 18'h3FFFF;
	localparam logic [ValW-1:0] LimitReset = 18'h3FFFF;

	typedef logic [ValW-1:0] val_t;

	typedef enum logic {
		FUNC_BUILD = 1'b0,
		FUNC_QUERY = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_RANGE     = 2'd1,
		STATUS_NOT_BUILT = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_SQ,
		ST_SRD,
		ST_SCHK,
		ST_MARK,
		ST_QRD,
		ST_QLAT,
		ST_DIV,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/core/prime_factor_sieve_table.sv
// Prime factor sieve table: builds a factor table in one large memory and
// answers factorization queries from it. Depends on pfst_pkg and the defines header.
`default_nettype none
`include "prime_factor_sieve_table_defines.svh"

// Usage
// - Command channel: drive func and query_value with start high; the item is
//   taken at the clock edge where start is high and busy is low.
// - func = build: the factor table is filled up to table_limit, then one item
//   with prime_factor 0, last 1, status ok comes out. A build first sets each
//   entry 1..limit to itself, one write per entry through the single memory
//   write port, then takes each sieve index i with i*i <= limit in turn and
//   marks the multiples of every prime index, from i*i up to the limit.
// - func = query: one result item per prime factor, last on the final one.
//   Each factor costs a memory read, a wait for the registered read data, the
//   bit-serial divider and an emit step; up to 17 factors.
//   Errors, n = 1 and a query before a build answer in the next cycle, from idle.
// - Results appear on result_valid for exactly one cycle; the receiver
//   cannot stall, so nothing is ever held back.
// - Config: cfg_we writes table_limit and drops the built flag; write only
//   while busy is low and no result is pending.
// - Reset: table_limit returns to its maximum and the table reads as not
//   built. The memory holds no reset value and needs no clearing pass.
module prime_factor_sieve_table (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  wire                   func,
	input  wire  [pfst_pkg::ValW-1:0] query_value,
	input  wire                   cfg_we,
	input  wire  [pfst_pkg::ValW-1:0] cfg_wdata,
	output logic                  result_valid,
	output logic [pfst_pkg::ValW-1:0] prime_factor,
	output logic                  last,
	output logic [1:0]            status
);
	import pfst_pkg::*;

	// Table storage: one write port, one registered read port.
	val_t mem [0:(1 << ValW)-1];
	val_t rdata_q;

	state_t state_q, state_d;

	val_t              table_limit_q;
	logic              built_q;
	val_t              lim;
	val_t              i_q;
	logic [ValW:0]     j_q;
	logic [2*ValW-1:0] sq_q;
	val_t              rem_q;
	val_t              p_q;
	val_t              div_r_q;
	val_t              div_q_q;
	logic [CntW-1:0]   cnt_q;
	logic [CntW-1:0]   k_q;
	logic [ValW:0]     div_rs;
	logic              div_ge;

	logic   mem_we;
	val_t   mem_waddr;
	val_t   mem_wdata;
	logic   rd_en;
	val_t   rd_addr;

	logic    res_valid_d;
	val_t    res_factor_d;
	logic    res_last_d;
	status_t res_status_d;

	always_comb begin
		lim = (table_limit_q > MaxValue) ? MaxValue : table_limit_q;
	end

	// One restoring division step: shift in the next dividend bit, subtract.
	always_comb begin
		div_rs = {div_r_q, div_q_q[ValW-1]};
		div_ge = (div_rs >= {1'b0, p_q});
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory port control and the result strobe.
	always_comb begin
		state_d      = state_q;
		mem_we       = 1'b0;
		mem_waddr    = j_q[ValW-1:0];
		mem_wdata    = i_q;
		rd_en        = 1'b0;
		rd_addr      = rem_q;
		res_valid_d  = 1'b0;
		res_factor_d = '0;
		res_last_d   = 1'b1;
		res_status_d = STATUS_OK;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (func_t'(func) == FUNC_BUILD) begin
						state_d = ST_INIT;
					end else if (!built_q) begin
						res_valid_d  = 1'b1;
						res_status_d = STATUS_NOT_BUILT;
					end else if (query_value == '0 || query_value > lim) begin
						res_valid_d  = 1'b1;
						res_status_d = STATUS_RANGE;
					end else if (query_value == val_t'(1)) begin
						res_valid_d = 1'b1;
					end else begin
						state_d = ST_QRD;
					end
				end
			end
			ST_INIT: begin
				// Every entry first maps to itself.
				if (j_q > {1'b0, lim}) begin
					state_d = ST_SQ;
				end else begin
					mem_we    = 1'b1;
					mem_wdata = j_q[ValW-1:0];
				end
			end
			ST_SQ: begin
				state_d = ST_SRD;
			end
			ST_SRD: begin
				if (sq_q > {{ValW{1'b0}}, lim}) begin
					// No index left whose square fits: table is complete.
					res_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = i_q;
					state_d = ST_SCHK;
				end
			end
			ST_SCHK: begin
				state_d = (rdata_q == i_q) ? ST_MARK : ST_SQ;
			end
			ST_MARK: begin
				if (j_q > {1'b0, lim}) begin
					state_d = ST_SQ;
				end else begin
					mem_we = 1'b1;
				end
			end
			ST_QRD: begin
				rd_en   = 1'b1;
				state_d = ST_QLAT;
			end
			ST_QLAT: begin
				if (rdata_q < val_t'(2)) begin
					// Broken entry ends the list.
					res_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (cnt_q == CntW'(ValW - 1)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				res_valid_d  = 1'b1;
				res_factor_d = p_q;
				res_last_d   = (div_q_q == val_t'(1)) || (k_q == CntW'(MaxResults - 1));
				state_d      = res_last_d ? ST_IDLE : ST_QRD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_limit_q <= LimitReset;
			built_q       <= 1'b0;
			result_valid  <= 1'b0;
		end else begin
			result_valid <= res_valid_d;
			if (cfg_we) begin
				table_limit_q <= cfg_wdata;
				built_q       <= 1'b0;
			end else if (state_q == ST_SRD && res_valid_d) begin
				built_q <= 1'b1;
			end
		end
	end

	// Datapath registers: counters, working value, divider.
	always_ff @(posedge clk) begin
		prime_factor <= res_factor_d;
		last         <= res_last_d;
		status       <= res_status_d;
		unique case (state_q)
			ST_IDLE: begin
				j_q   <= {{ValW{1'b0}}, 1'b1};
				i_q   <= val_t'(2);
				rem_q <= query_value;
				k_q   <= '0;
			end
			ST_INIT: begin
				j_q <= j_q + 1'b1;
			end
			ST_SQ: begin
				sq_q <= (2*ValW)'(i_q) * (2*ValW)'(i_q);
			end
			ST_SCHK: begin
				if (rdata_q == i_q) begin
					j_q <= sq_q[ValW:0];
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
			ST_MARK: begin
				if (j_q > {1'b0, lim}) begin
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + {1'b0, i_q};
				end
			end
			ST_QLAT: begin
				p_q     <= rdata_q;
				div_r_q <= '0;
				div_q_q <= rem_q;
				cnt_q   <= '0;
			end
			ST_DIV: begin
				cnt_q <= cnt_q + 1'b1;
				if (div_ge) begin
					div_r_q <= ValW'(div_rs - {1'b0, p_q});
				end else begin
					div_r_q <= div_rs[ValW-1:0];
				end
				div_q_q <= {div_q_q[ValW-2:0], div_ge};
			end
			ST_EMIT: begin
				rem_q <= div_q_q;
				k_q   <= k_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Table memory.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	`PFST_ASSERT_SAME(a_err_is_last, result_valid && status != STATUS_OK, last,
		"error result without last")
	`PFST_ASSERT_SAME(a_mid_factor_prime, result_valid && !last, prime_factor >= val_t'(2),
		"non-final result carries no factor")
	`PFST_ASSERT_SAME(a_busy_ends_in_result, $fell(busy), result_valid,
		"busy dropped without a result")
	`PFST_ASSERT_NEXT(a_cfg_clears_built, cfg_we, !built_q,
		"limit write kept the table marked built")

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for prime_factor_sieve_table: drives build and factor-query items,
// predicts every result item with its own sieve, and compares each one on the fly.
// Depends on pfst_pkg and the prime_factor_sieve_table RTL.
module tb;
	import pfst_pkg::*;

	// Random items spread over the small-table phases.
	localparam int RANDOM_ITEMS = 280;
	// Random queries against the full-size table.
	localparam int FULL_RANDOM  = 40;
	// Run limit for the watchdog, with room for a full-size build.
	localparam int CYCLE_LIMIT  = 8_000_000;

	typedef struct {
		val_t    factor;
		logic    last;
		status_t status;
	} factor_res_t;

	logic       clk;
	logic       arst_n      = 1'b0;
	logic       start       = 1'b0;
	logic       func        = 1'b0;
	val_t       query_value = '0;
	logic       cfg_we      = 1'b0;
	val_t       cfg_wdata   = '0;
	logic       busy;
	logic       result_valid;
	val_t       prime_factor;
	logic       last;
	logic [1:0] status;

	// Predictor state: sieve table, its limit and the built flag.
	bit [ValW-1:0] sieve_tbl [0:int'(MaxValue)];
	val_t          tbl_limit = LimitReset;
	bit            tbl_built = 1'b0;

	// Result items still due from the block, oldest first.
	factor_res_t factor_q[$];
	factor_res_t want;

	int error_count = 0;
	int burst_left  = 0;
	int cycle_count;

	prime_factor_sieve_table u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.query_value  (query_value),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.prime_factor (prime_factor),
		.last         (last),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Fill entries 1..limit the same way the block does: identity first, then mark
	// multiples of every index that still maps to itself, starting at its square.
	function automatic void fill_sieve();
		int lim, i, j;
		lim = int'(tbl_limit);
		for (j = 1; j <= lim; j++)
			sieve_tbl[j] = val_t'(j);
		for (i = 2; i * i <= lim; i++) begin
			if (sieve_tbl[i] == val_t'(i)) begin
				for (j = i * i; j <= lim; j += i)
					sieve_tbl[j] = val_t'(i);
			end
		end
		tbl_built = 1'b1;
	endfunction

	// Append one expected result item behind the ones already due.
	function automatic void expect_result(input factor_res_t r);
		factor_q.insert(factor_q.size(), r);
	endfunction

	// Queue the result items that one accepted item is to produce.
	function automatic void predict_factors(input func_t f, input val_t v);
		factor_res_t r;
		factor_res_t run_q[$];
		val_t        work, p;
		int          k;
		bit          stop;
		r.factor = '0;
		r.last   = 1'b1;
		r.status = STATUS_OK;
		if (f == FUNC_BUILD) begin
			fill_sieve();
			expect_result(r);
		end else if (!tbl_built) begin
			// The not-built check wins over the range check, even for zero.
			r.status = STATUS_NOT_BUILT;
			expect_result(r);
		end else if (v == '0 || v > tbl_limit) begin
			r.status = STATUS_RANGE;
			expect_result(r);
		end else if (v == val_t'(1)) begin
			expect_result(r);
		end else begin
			// Walk the table: read the entry at the working value, divide it out.
			work = v;
			k    = 0;
			stop = 1'b0;
			while (!stop && work != val_t'(1) && k < MaxResults) begin
				p = sieve_tbl[work];
				if (p < val_t'(2)) begin
					stop = 1'b1;
				end else begin
					r.factor = p;
					r.last   = 1'b0;
					run_q.insert(run_q.size(), r);
					k++;
					work = work / p;
				end
			end
			if (run_q.size() == 0) begin
				r.factor = '0;
				r.last   = 1'b1;
				run_q.insert(run_q.size(), r);
			end
			run_q[run_q.size() - 1].last = 1'b1;
			foreach (run_q[idx])
				expect_result(run_q[idx]);
		end
	endfunction

	// Send one item. Open a random gap before each burst, then hold start until busy
	// is seen low at a falling edge: the next rising edge takes the item.
	task automatic send_item(input func_t f, input val_t v);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 30);
			if ($urandom_range(0, 7) == 0)
				gap = $urandom_range(40, 200);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
			// Mostly short bursts, now and then a long run with no gaps at all.
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
			                                         : $urandom_range(1, 8);
		end
		burst_left--;
		start       <= 1'b1;
		func        <= f;
		query_value <= v;
		@(negedge clk);
		while (busy) begin
			@(posedge clk);
			@(negedge clk);
		end
		@(posedge clk);
		predict_factors(f, v);
	endtask

	// Drop start and wait until the block is idle with nothing left to come.
	task automatic drain_results(input int tail);
		start <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (busy || factor_q.size() != 0)
			@(negedge clk);
		repeat (tail) @(posedge clk);
	endtask

	// Write table_limit; the block drops its built flag on every write.
	task automatic write_limit(input val_t v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		tbl_limit = v;
		tbl_built = 1'b0;
	endtask

	// Pick a query value for a table of limit lim: mostly in range, some edges,
	// some powers of two for long factor lists, some zero and out-of-range noise.
	function automatic val_t pick_query(input val_t lim);
		int   r;
		val_t v;
		r = $urandom_range(0, 99);
		if (r < 6) begin
			v = '0;
		end else if (r < 16) begin
			v = val_t'($urandom_range(0, int'(MaxValue)));
		end else if (r < 20) begin
			v = lim;
		end else if (r < 24) begin
			v = lim + val_t'(1);
		end else if (r < 27) begin
			v = val_t'(1);
		end else if (r < 37) begin
			v = val_t'(2);
			repeat ($urandom_range(0, 17))
				if (v * 2 <= lim)
					v = {v[ValW-2:0], 1'b0};
		end else begin
			v = val_t'($urandom_range(2, int'(lim)));
		end
		return v;
	endfunction

	// Check every result item against the oldest expectation. Falling-edge sampling
	// sees the values that the closing rising edge takes.
	always @(negedge clk) begin
		if (arst_n && result_valid) begin
			if (factor_q.size() == 0) begin
				$display("%0t: result with none expected: factor=%0d last=%0b status=%0d",
				         $time, prime_factor, last, status);
				error_count++;
			end else begin
				want = factor_q.pop_front();
				if (prime_factor !== want.factor) begin
					$display("%0t: prime_factor mismatch: expected %0d, actual %0d",
					         $time, want.factor, prime_factor);
					error_count++;
				end
				if (last !== want.last) begin
					$display("%0t: last mismatch: expected %0b, actual %0b",
					         $time, want.last, last);
					error_count++;
				end
				if (status !== want.status) begin
					$display("%0t: status mismatch: expected %0d, actual %0d",
					         $time, want.status, status);
					error_count++;
				end
			end
		end
	end

	// Queries right after reset: the table is not built yet, even at the extremes.
	task automatic test_unbuilt_queries();
		send_item(FUNC_QUERY, '0);
		send_item(FUNC_QUERY, val_t'(1));
		send_item(FUNC_QUERY, MaxValue);
		send_item(FUNC_QUERY, 18'h15555);
		drain_results(8);
	endtask

	// Smallest table: limit 2, then out of range on both sides, and a rewrite
	// of the limit that leaves the table unbuilt again.
	task automatic test_smallest_table();
		write_limit(val_t'(2));
		send_item(FUNC_BUILD, 18'h2AAAA);
		send_item(FUNC_QUERY, '0);
		send_item(FUNC_QUERY, val_t'(1));
		send_item(FUNC_QUERY, val_t'(2));
		send_item(FUNC_QUERY, val_t'(3));
		send_item(FUNC_QUERY, MaxValue);
		drain_results(8);
		write_limit(val_t'(2));
		send_item(FUNC_QUERY, val_t'(2));
		drain_results(8);
	endtask

	// Full-size table: one long build, then the longest factor list (2^17),
	// the top value and random queries over the whole field.
	task automatic test_full_table();
		int   n;
		val_t v;
		write_limit(MaxValue);
		send_item(FUNC_BUILD, '0);
		send_item(FUNC_QUERY, 18'h20000);
		send_item(FUNC_QUERY, MaxValue);
		send_item(FUNC_QUERY, MaxValue - val_t'(1));
		send_item(FUNC_QUERY, 18'h30000);
		send_item(FUNC_QUERY, 18'h2AAAA);
		send_item(FUNC_QUERY, val_t'(1));
		send_item(FUNC_QUERY, '0);
		for (n = 0; n < FULL_RANDOM; n++) begin
			v = ($urandom_range(0, 3) == 0) ? pick_query(MaxValue)
			                                : val_t'($urandom_range(0, int'(MaxValue)));
			send_item(FUNC_QUERY, v);
		end
		drain_results(8);
	endtask

	// Random phases on small tables: new limit, sometimes a query before the build,
	// then a run of mostly well-formed queries with a rebuild now and then.
	task automatic test_random_phases();
		int   sent, n_items, n, sel;
		val_t lim;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 9);
			if (sel == 0)
				lim = val_t'(2);
			else if (sel < 3)
				lim = val_t'($urandom_range(600, 4000));
			else
				lim = val_t'($urandom_range(3, 600));
			write_limit(lim);
			if ($urandom_range(0, 3) == 0) begin
				send_item(FUNC_QUERY, val_t'($urandom_range(0, int'(MaxValue))));
				sent++;
			end
			send_item(FUNC_BUILD, val_t'($urandom));
			sent++;
			n_items = $urandom_range(15, 40);
			for (n = 0; n < n_items; n++) begin
				if ($urandom_range(0, 19) == 0)
					send_item(FUNC_BUILD, val_t'($urandom));
				else
					send_item(FUNC_QUERY, pick_query(lim));
				sent++;
			end
			drain_results(8);
		end
	endtask

	// Watchdog: end the run if the cycle count runs past the limit.
	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		// Hold reset from the start, release it on a rising edge.
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unbuilt_queries();
		test_smallest_table();
		test_full_table();
		test_random_phases();

		// Let any stray result item show up before the verdict.
		drain_results(40);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
